>>> rtl/rrbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrbc_pkg
// Shared types and constants of the cartridge ROM/RAM bank controller.
// ----------------------------------------------------------------------------
package rrbc_pkg;

	localparam int ADDR_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int CART_W     = 8;
	localparam int COUNT_W    = 10;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 10;
	localparam int ROM_BANK_W = 7;
	localparam int RAM_BANK_W = 2;
	localparam int ROM_OFS_W  = 21;
	localparam int RAM_OFS_W  = 15;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CART_TYPE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT = 8'd1;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic calc_done;
		logic out_free;
	} dp_sts_t;

endpackage : rrbc_pkg
`default_nettype wire

>>> rtl/rom_ram_bank_controller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rom_ram_bank_controller_unit
// Cartridge bank controller: CPU writes in, current bank mapping out.
// ----------------------------------------------------------------------------
// Input channel: one beat per CPU write (write_address, write_byte), taken
// when in_valid is high and in_stall low. Every beat yields exactly one
// result beat with the mapping after that write, ignored writes included.
// Configuration: cfg_valid/cfg_ready carry cfg_index (0 cartridge type,
// 1 ROM bank count) and cfg_data; cfg_ready is always high.
// Sequence: a ROM bank write runs accept, two remainder steps of four bits
// each, then commit before the next acceptance; any other write passes the
// calc state once and goes on to commit. The result appears on the output
// register the cycle after commit. One write is in flight at a time; a new
// beat is taken while the previous result still waits at the output.
// Reset: arst_n clears bank state to ROM bank 1, RAM bank 0, RAM off,
// mode 0; cartridge type 1, bank count 2; no result pending.
// Stall: a stalled result holds; the controller waits at commit until the
// output register frees up, and in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
module rom_ram_bank_controller_unit
	import rrbc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [ADDR_W-1:0]     write_address,
	input  wire logic [BYTE_W-1:0]     write_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [ROM_BANK_W-1:0]      current_rom_bank,
	output logic [ROM_OFS_W-1:0]       rom_byte_offset,
	output logic [RAM_BANK_W-1:0]      current_ram_bank,
	output logic [RAM_OFS_W-1:0]       ram_byte_offset,
	output logic                       ram_on,
	output logic                       bank_mode
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	rrbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	rrbc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.write_address    (write_address),
		.write_byte       (write_byte),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.current_rom_bank (current_rom_bank),
		.rom_byte_offset  (rom_byte_offset),
		.current_ram_bank (current_ram_bank),
		.ram_byte_offset  (ram_byte_offset),
		.ram_on           (ram_on),
		.bank_mode        (bank_mode),
		.cmd              (cmd),
		.sts              (sts)
	);

endmodule : rom_ram_bank_controller_unit
`default_nettype wire

>>> rtl/rrbc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrbc_ctrl
// Sequencer: accept a write beat, run the bank wrap, commit the result.
// ----------------------------------------------------------------------------
module rrbc_ctrl
	import rrbc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   stall_q;

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.step   = (state_q == ST_CALC);
		cmd.commit = (state_q == ST_COMMIT) && sts.out_free;
	end

	assign in_stall = stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CALC;
						stall_q <= 1'b1;
					end
				end
				ST_CALC: begin
					if (sts.calc_done) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					// hold until the output register is free
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule : rrbc_ctrl
`default_nettype wire

>>> rtl/rrbc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrbc_dp
// Datapath: configuration, write decode, radix-16 remainder unit for the
// ROM bank wrap, bank-control state and the output register.
// ----------------------------------------------------------------------------
module rrbc_dp
	import rrbc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [ADDR_W-1:0]     write_address,
	input  wire logic [BYTE_W-1:0]     write_byte,
	input  wire logic                  out_stall,
	output logic                       out_valid,
	output logic [ROM_BANK_W-1:0]      current_rom_bank,
	output logic [ROM_OFS_W-1:0]       rom_byte_offset,
	output logic [RAM_BANK_W-1:0]      current_ram_bank,
	output logic [RAM_OFS_W-1:0]       ram_byte_offset,
	output logic                       ram_on,
	output logic                       bank_mode,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts
);

	localparam int NUM_W   = 8;
	localparam int RADIX_W = 4;
	localparam int STEPS   = NUM_W / RADIX_W;
	localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_RAM_EN,
		OP_ROM_BANK,
		OP_RAM_BANK,
		OP_MODE
	} op_t;

	logic [CART_W-1:0]     cart_type_q;
	logic [COUNT_W-1:0]    bank_count_q;
	logic [ROM_BANK_W-1:0] rom_bank_q;
	logic [RAM_BANK_W-1:0] ram_bank_q;
	logic                  ram_en_q;
	logic                  mode_q;

	op_t                   op_q;
	logic [BYTE_W-1:0]     byte_q;
	logic [NUM_W-1:0]      num_q;
	logic [COUNT_W-1:0]    rem_q;
	logic [STEP_W-1:0]     step_q;
	logic                  out_valid_q;

	op_t                   op_dec;
	logic [NUM_W-1:0]      num_dec;
	logic [COUNT_W-1:0]    divisor;
	logic [COUNT_W-1:0]    rem_nxt;
	logic [ROM_BANK_W-1:0] rom_nxt;
	logic [RAM_BANK_W-1:0] ram_nxt;
	logic                  ram_en_nxt;
	logic                  mode_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type_q  <= CART_W'(1);
			bank_count_q <= COUNT_W'(2);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CART_TYPE:  cart_type_q  <= cfg_data[CART_W-1:0];
				CFG_BANK_COUNT: bank_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// write decode
	always_comb begin
		op_dec  = OP_NONE;
		num_dec = {3'b000, write_byte[4:0]};
		if (!write_address[15]) begin
			if (cart_type_q inside {[8'd1:8'd3]}) begin
				case (write_address[14:13])
					2'd0: op_dec = OP_RAM_EN;
					2'd1: op_dec = OP_ROM_BANK;
					2'd2: begin
						if (!mode_q) begin
							op_dec  = OP_ROM_BANK;
							num_dec = {1'b0, write_byte[1:0], rom_bank_q[4:0]};
						end else begin
							op_dec = OP_RAM_BANK;
						end
					end
					default: op_dec = OP_MODE;
				endcase
			end else if (cart_type_q inside {8'd5, 8'd6}) begin
				if (write_address[14:8] == 7'h21) op_dec = OP_ROM_BANK;
			end
		end
	end

	// a zero bank count behaves as one
	assign divisor = (bank_count_q == '0) ? COUNT_W'(1) : bank_count_q;

	// restoring remainder, RADIX_W numerator bits a cycle
	always_comb begin
		logic [COUNT_W:0]   part;
		logic [COUNT_W-1:0] r;
		r    = rem_q;
		part = '0;
		for (int k = 0; k < RADIX_W; k++) begin
			part = {r, num_q[NUM_W-1-k]};
			if (part >= {1'b0, divisor}) part = part - {1'b0, divisor};
			r = part[COUNT_W-1:0];
		end
		rem_nxt = r;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_dec;
			byte_q <= write_byte;
			num_q  <= num_dec;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.step) begin
			num_q  <= num_q << RADIX_W;
			rem_q  <= rem_nxt;
			step_q <= step_q + STEP_W'(1);
		end
	end

	// next bank-control state
	always_comb begin
		rom_nxt    = rom_bank_q;
		ram_nxt    = ram_bank_q;
		ram_en_nxt = ram_en_q;
		mode_nxt   = mode_q;
		case (op_q)
			OP_RAM_EN:   ram_en_nxt = (byte_q[3:0] == 4'hA);
			OP_ROM_BANK: rom_nxt = (rem_q == '0) ? ROM_BANK_W'(1) : rem_q[ROM_BANK_W-1:0];
			OP_RAM_BANK: ram_nxt = byte_q[RAM_BANK_W-1:0];
			OP_MODE:     mode_nxt = byte_q[0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q  <= ROM_BANK_W'(1);
			ram_bank_q  <= '0;
			ram_en_q    <= 1'b0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				rom_bank_q  <= rom_nxt;
				ram_bank_q  <= ram_nxt;
				ram_en_q    <= ram_en_nxt;
				mode_q      <= mode_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			current_rom_bank <= rom_nxt;
			rom_byte_offset  <= {rom_nxt - ROM_BANK_W'(1), 14'b0};
			current_ram_bank <= ram_nxt;
			ram_byte_offset  <= {ram_nxt, 13'b0};
			ram_on           <= ram_en_nxt;
			bank_mode        <= mode_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.calc_done = (op_q != OP_ROM_BANK) || (step_q == LAST_STEP);

endmodule : rrbc_dp
`default_nettype wire

>>> rtl/rrbc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrbc_checker
// Port-level checks of the bank controller, bound to the top level.
// ----------------------------------------------------------------------------
module rrbc_checker
	import rrbc_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [ROM_BANK_W-1:0] current_rom_bank,
	input wire logic [ROM_OFS_W-1:0]  rom_byte_offset,
	input wire logic [RAM_BANK_W-1:0] current_ram_bank,
	input wire logic [RAM_OFS_W-1:0]  ram_byte_offset
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(current_rom_bank)
			&& $stable(current_ram_bank))
		else $error("stalled result changed");

	// one write in flight: busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	a_rom_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> current_rom_bank != '0)
		else $error("ROM bank zero reported");

	a_rom_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rom_byte_offset[13:0] == 14'd0
			&& rom_byte_offset[20:14] == current_rom_bank - 7'd1)
		else $error("ROM offset does not match bank");

	a_ram_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ram_byte_offset[12:0] == 13'd0
			&& ram_byte_offset[14:13] == current_ram_bank)
		else $error("RAM offset does not match bank");

endmodule : rrbc_checker

bind rom_ram_bank_controller_unit rrbc_checker u_rrbc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.current_rom_bank (current_rom_bank),
	.rom_byte_offset  (rom_byte_offset),
	.current_ram_bank (current_ram_bank),
	.ram_byte_offset  (ram_byte_offset)
);
`default_nettype wire

>>> bench/tb_rom_ram_bank_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_rom_ram_bank_controller_unit
// Self-checking bench for the cartridge bank controller. A short scripted
// sequence covers the address regions, both controller kinds, unknown types
// and the edge bank counts. Random phases follow, each with fresh register
// settings. Every result beat is compared field by field against a pinned
// expectation or a model of the mapping. Both handshakes see random gaps.
// ----------------------------------------------------------------------------
module tb_rom_ram_bank_controller_unit
	import rrbc_pkg::*;
();

	localparam int PHASES         = 17;
	localparam int PHASE_WRITES   = 50;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	// address decode of cartridge space
	localparam logic [ADDR_W-1:0] RAM_EN_END     = 16'h2000;
	localparam logic [ADDR_W-1:0] ROM_LO_END     = 16'h4000;
	localparam logic [ADDR_W-1:0] UPPER_END      = 16'h6000;
	localparam logic [ADDR_W-1:0] CART_SPACE_END = 16'h8000;
	localparam logic [ADDR_W-1:0] ALT_BANK_LO    = 16'h2100;
	localparam logic [ADDR_W-1:0] ALT_BANK_HI    = 16'h21FF;
	localparam logic [3:0]        RAM_KEY        = 4'hA;
	localparam int                ROM_PAGE       = 'h4000;
	localparam int                RAM_PAGE       = 'h2000;

	// cartridge type codes per controller kind
	localparam int CART_FIRST_LO  = 1;
	localparam int CART_FIRST_HI  = 3;
	localparam int CART_SECOND_LO = 5;
	localparam int CART_SECOND_HI = 6;
	localparam int CART_TYPE_MAX  = 255;
	localparam int BANK_COUNT_MAX = 1023;

	typedef struct packed {
		logic [ROM_BANK_W-1:0] rom_bank;
		logic [ROM_OFS_W-1:0]  rom_ofs;
		logic [RAM_BANK_W-1:0] ram_bank;
		logic [RAM_OFS_W-1:0]  ram_ofs;
		logic                  ram_on;
		logic                  mode;
	} mapping_t;

	typedef enum logic {ROW_WRITE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [ADDR_W-1:0]    addr;
		logic [BYTE_W-1:0]    data;
		logic [CFG_IDX_W-1:0] idx;
		int unsigned          value;
		logic                 pin;
		mapping_t             want;
	} row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  in_valid      = 1'b0;
	logic                  in_stall;
	logic [ADDR_W-1:0]     write_address = '0;
	logic [BYTE_W-1:0]     write_byte    = '0;
	logic                  out_valid;
	logic                  out_stall     = 1'b0;
	logic [ROM_BANK_W-1:0] current_rom_bank;
	logic [ROM_OFS_W-1:0]  rom_byte_offset;
	logic [RAM_BANK_W-1:0] current_ram_bank;
	logic [RAM_OFS_W-1:0]  ram_byte_offset;
	logic                  ram_on;
	logic                  bank_mode;

	// model state and register copies
	logic [CART_W-1:0]     cart_type_r  = 8'd1;
	logic [COUNT_W-1:0]    bank_count_r = 10'd2;
	logic [ROM_BANK_W-1:0] rom_bank_r   = 7'd1;
	logic [RAM_BANK_W-1:0] ram_bank_r   = 2'd0;
	logic                  ram_on_r     = 1'b0;
	logic                  mode_r       = 1'b0;

	mapping_t expected_maps[$];
	row_t     script[$];
	logic     quiet        = 1'b0;
	int       fail_count   = 0;
	int       writes_sent  = 0;
	int       reg_writes   = 0;
	int       maps_checked = 0;
	int       stall_left   = 0;
	int       idle_cycles  = 0;

	rom_ram_bank_controller_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.write_address    (write_address),
		.write_byte       (write_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.current_rom_bank (current_rom_bank),
		.rom_byte_offset  (rom_byte_offset),
		.current_ram_bank (current_ram_bank),
		.ram_byte_offset  (ram_byte_offset),
		.ram_on           (ram_on),
		.bank_mode        (bank_mode)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic is_first_kind(input logic [CART_W-1:0] t);
		return t >= CART_FIRST_LO && t <= CART_FIRST_HI;
	endfunction

	function automatic logic is_second_kind(input logic [CART_W-1:0] t);
		return t >= CART_SECOND_LO && t <= CART_SECOND_HI;
	endfunction

	// a zero count behaves as one; the bank never drops below one
	function automatic logic [ROM_BANK_W-1:0] wrap_rom_bank(input int unsigned bank);
		int unsigned n;
		n = (bank_count_r == 0) ? 1 : bank_count_r;
		if (bank >= n)
			bank = bank % n;
		if (bank < 1)
			bank = 1;
		return ROM_BANK_W'(bank);
	endfunction

	function automatic mapping_t apply_write(input logic [ADDR_W-1:0] a,
			input logic [BYTE_W-1:0] d);
		mapping_t m;
		if (a < CART_SPACE_END) begin
			if (is_first_kind(cart_type_r)) begin
				if (a < RAM_EN_END)
					ram_on_r = (d[3:0] == RAM_KEY);
				else if (a < ROM_LO_END)
					rom_bank_r = wrap_rom_bank(d[4:0]);
				else if (a < UPPER_END) begin
					if (!mode_r)
						rom_bank_r = wrap_rom_bank({d[1:0], rom_bank_r[4:0]});
					else
						ram_bank_r = d[1:0];
				end else
					mode_r = d[0];
			end else if (is_second_kind(cart_type_r)) begin
				if (a >= ALT_BANK_LO && a <= ALT_BANK_HI)
					rom_bank_r = wrap_rom_bank(d[4:0]);
			end
		end
		m.rom_bank = rom_bank_r;
		m.rom_ofs  = ROM_OFS_W'(ROM_BANK_W'(rom_bank_r - 7'd1)) * ROM_OFS_W'(ROM_PAGE);
		m.ram_bank = ram_bank_r;
		m.ram_ofs  = RAM_OFS_W'(ram_bank_r) * RAM_OFS_W'(RAM_PAGE);
		m.ram_on   = ram_on_r;
		m.mode     = mode_r;
		return m;
	endfunction

	function automatic mapping_t mapping_of(input int rom, input int rom_ofs, input int ram,
			input int ram_ofs, input int on, input int md);
		mapping_t m;
		m.rom_bank = ROM_BANK_W'(rom);
		m.rom_ofs  = ROM_OFS_W'(rom_ofs);
		m.ram_bank = RAM_BANK_W'(ram);
		m.ram_ofs  = RAM_OFS_W'(ram_ofs);
		m.ram_on   = 1'(on);
		m.mode     = 1'(md);
		return m;
	endfunction

	function automatic void add_write(input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] d);
		row_t r;
		r.kind = ROW_WRITE;
		r.addr = a;
		r.data = d;
		r.pin  = 1'b0;
		r.want = '0;
		script.push_back(r);
	endfunction

	function automatic void add_pinned(input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] d,
			input mapping_t m);
		row_t r;
		r.kind = ROW_WRITE;
		r.addr = a;
		r.data = d;
		r.pin  = 1'b1;
		r.want = m;
		script.push_back(r);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] i, input int unsigned v);
		row_t r;
		r.kind  = ROW_CFG;
		r.idx   = i;
		r.value = v;
		r.pin   = 1'b0;
		r.want  = '0;
		script.push_back(r);
	endfunction

	// mostly short, now and then long; nothing in a quiet phase
	function automatic int pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned pick_cart_type();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(CART_FIRST_LO, CART_FIRST_HI);
		if (r < 8)
			return $urandom_range(CART_SECOND_LO, CART_SECOND_HI);
		return $urandom_range(0, CART_TYPE_MAX);
	endfunction

	function automatic int unsigned pick_bank_count();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return $urandom_range(2, 8);
			3: return $urandom_range(9, 64);
			4: return 127;
			5: return 128;
			6: return 512;
			7: return BANK_COUNT_MAX;
			default: return $urandom_range(1, 512);
		endcase
	endfunction

	// mostly writes that the current controller kind decodes, some noise
	function automatic logic [ADDR_W-1:0] random_write_address();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (is_first_kind(cart_type_r) && r < 85)
			return ADDR_W'($urandom_range(0, 3) * RAM_PAGE + $urandom_range(0, RAM_PAGE - 1));
		if (is_second_kind(cart_type_r) && r < 60)
			return ADDR_W'($urandom_range(ALT_BANK_LO, ALT_BANK_HI));
		if (r < 85)
			return ADDR_W'($urandom_range(0, CART_SPACE_END - 1));
		return ADDR_W'($urandom);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// wait for every mapping to drain, then write; hold valid when another follows
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
			input logic more);
		while (expected_maps.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		if (!more)
			cfg_valid <= 1'b0;
		if (idx == CFG_CART_TYPE)
			cart_type_r = CART_W'(value);
		else if (idx == CFG_BANK_COUNT)
			bank_count_r = COUNT_W'(value);
		reg_writes++;
	endtask

	task automatic send_write(input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] d,
			input logic pin, input mapping_t want, input logic last);
		mapping_t m;
		int gap;
		in_valid      <= 1'b1;
		write_address <= a;
		write_byte    <= d;
		do @(posedge clk); while (in_stall);
		m = apply_write(a, d);
		expected_maps.push_back(pin ? want : m);
		writes_sent++;
		gap = last ? 0 : pick_pause();
		if (last || gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: check each beat taken, then choose the next stall
	always @(posedge clk) begin
		mapping_t want;
		if (out_valid && !out_stall) begin
			if (expected_maps.size() == 0) begin
				$error("result beat with nothing outstanding: rom bank %0d", current_rom_bank);
				fail_count++;
			end else begin
				want = expected_maps.pop_front();
				check_field("current_rom_bank", want.rom_bank, current_rom_bank);
				check_field("rom_byte_offset", want.rom_ofs, rom_byte_offset);
				check_field("current_ram_bank", want.ram_bank, current_ram_bank);
				check_field("ram_byte_offset", want.ram_ofs, ram_byte_offset);
				check_field("ram_on", want.ram_on, ram_on);
				check_field("bank_mode", want.mode, bank_mode);
				maps_checked++;
			end
		end
		if (quiet)
			out_stall <= 1'b0;
		else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_pause();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$error("no beat moved for %0d cycles", idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		// reset state: type 1, two banks
		add_pinned(16'hFFFF, 8'hFF, mapping_of(1, 0, 0, 0, 0, 0));
		add_pinned(16'h0000, 8'h0A, mapping_of(1, 0, 0, 0, 1, 0));
		add_pinned(16'h1FFF, 8'hFA, mapping_of(1, 0, 0, 0, 1, 0));
		add_pinned(16'h1000, 8'h0B, mapping_of(1, 0, 0, 0, 0, 0));
		add_pinned(16'h2000, 8'h00, mapping_of(1, 0, 0, 0, 0, 0));
		add_write(16'h3FFF, 8'h1F);
		add_cfg(CFG_BANK_COUNT, 128);
		add_write(16'h2000, 8'h1F);
		add_pinned(16'h4000, 8'h03, mapping_of(127, 2064384, 0, 0, 0, 0));
		add_write(16'h6000, 8'h01);
		add_pinned(16'h5FFF, 8'hFF, mapping_of(127, 2064384, 3, 24576, 0, 1));
		add_write(16'h7FFF, 8'hFE);
		add_write(16'h8000, 8'h55);
		// zero count: every bank collapses to one
		add_cfg(CFG_BANK_COUNT, 0);
		add_pinned(16'h2000, 8'h10, mapping_of(1, 0, 3, 24576, 0, 0));
		add_write(16'h4000, 8'h02);
		add_cfg(CFG_BANK_COUNT, BANK_COUNT_MAX);
		add_write(16'h4000, 8'h03);
		// second kind: only the narrow bank window decodes
		add_cfg(CFG_CART_TYPE, CART_SECOND_LO);
		add_write(16'h2100, 8'h05);
		add_write(16'h21FF, 8'hFF);
		add_write(16'h20FF, 8'h03);
		add_write(16'h2200, 8'h03);
		add_write(16'h0000, 8'h0A);
		add_write(16'h6000, 8'h01);
		add_cfg(CFG_CART_TYPE, 0);
		add_write(16'h2000, 8'h07);
		add_cfg(CFG_CART_TYPE, CART_TYPE_MAX);
		add_write(16'h0000, 8'h0A);
		add_cfg(CFG_CART_TYPE, CART_FIRST_HI);
		add_cfg(CFG_BANK_COUNT, 512);
		add_write(16'h2000, 8'h00);
		add_write(16'h4000, 8'h01);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				write_reg(script[i].idx, script[i].value,
					i + 1 < script.size() && script[i + 1].kind == ROW_CFG);
			else
				send_write(script[i].addr, script[i].data, script[i].pin, script[i].want,
					i + 1 == script.size() || script[i + 1].kind == ROW_CFG);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_CART_TYPE, pick_cart_type(), 1'b1);
			write_reg(CFG_BANK_COUNT, pick_bank_count(), 1'b0);
			quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_WRITES; k++)
				send_write(random_write_address(), BYTE_W'($urandom), 1'b0, '0,
					k == PHASE_WRITES - 1);
		end

		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d CPU writes under %0d register writes; %0d mappings compared, %0d mismatches",
			writes_sent, reg_writes, maps_checked, fail_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/rrbc_pkg.sv
rtl/rrbc_ctrl.sv
rtl/rrbc_dp.sv
rtl/rom_ram_bank_controller_unit.sv
rtl/rrbc_checker.sv
bench/tb_rom_ram_bank_controller_unit.sv
